// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;   // power of two
  localparam int CELLS    = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int CELL_W = 16;
  localparam int POS_W  = 11;

  // op codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;

  // config register indexes
  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic [CUR_W-1:0] pos;
    logic [COL_W-1:0] col;
    logic             write_en;
    logic             scroll;
  } cur_upd_t;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_cursor.sv =====
module tcw_cursor (
  input  logic [tcw_pkg::CUR_W-1:0] cursor,
  input  logic [tcw_pkg::COL_W-1:0] col,
  input  logic [7:0]                char_code,
  output tcw_pkg::cur_upd_t         upd
);
  import tcw_pkg::*;

  logic [CUR_W-1:0] row_start;
  logic [CUR_W-1:0] tab_step;
  logic [CUR_W-1:0] tab_col;

  assign row_start = cursor - CUR_W'(col);
  assign tab_step  = CUR_W'(TAB_STOP) - (cursor % CUR_W'(TAB_STOP));

  always_comb begin
    tab_col = CUR_W'(col) + tab_step;
    if (tab_col >= CUR_W'(COLUMNS)) begin
      tab_col = tab_col - CUR_W'(COLUMNS);
    end
  end

  always_comb begin
    upd.pos      = cursor;
    upd.col      = col;
    upd.write_en = 1'b0;
    case (char_code)
      CH_LF: begin
        upd.pos = row_start + CUR_W'(COLUMNS);
        upd.col = '0;
      end
      CH_CR: begin
        upd.pos = row_start;
        upd.col = '0;
      end
      CH_BS: begin
        if (cursor != '0) begin
          upd.pos = cursor - CUR_W'(1);
          upd.col = (col == '0) ? COL_W'(COLUMNS - 1) : col - COL_W'(1);
        end
      end
      CH_TAB: begin
        upd.pos = cursor + tab_step;
        upd.col = COL_W'(tab_col);
      end
      default: begin
        if (char_code inside {[CH_SPACE:CH_TILDE]}) begin
          upd.pos      = cursor + CUR_W'(1);
          upd.col      = (col == COL_W'(COLUMNS - 1)) ? '0 : col + COL_W'(1);
          upd.write_en = 1'b1;
        end
      end
    endcase
    // wrapped past the last cell
    upd.scroll = (upd.pos >= CUR_W'(CELLS));
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer: an 80x25 cell store (colour byte over character byte)
// with a cursor, driven by a stream of put / clear / read transactions.
// Input channel in_valid/in_ready/in_data carries one op per transaction;
// every op returns exactly one result transaction on out_valid/out_ready/
// out_data (cursor after the op, read cell data, scroll flag).
// Config port: cfg_we with cfg_index 0 = foreground, 1 = background nibble.
// Path from acceptance to the result register:
//   put, no scroll / unused op : one transaction per cycle, output unstalled
//   read                       : S_READ (synchronous store read)
//   clear                      : S_FILL (blank fill sweep)
//   put that scrolls           : S_SCROLL (row copy), then S_FILL (blank
//                                the last row), one cell per cycle
// The store is a single memory with one write and one read port; the
// sweeps touch one cell per cycle.
// Reset: cursor homed, colours to 7/0, then a clearing pass over every cell
// zeroes the store; in_ready stays low throughout.
// A stalled receiver: the result register holds; the next op is still taken,
// and its result waits in a holding register, in_ready low, until the
// output register frees.
module text_console_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_wdata
);
  import tcw_pkg::*;

  // controller states
  localparam logic [2:0] S_INIT   = 3'd0;  // post-reset zeroing pass
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;  // copy rows up
  localparam logic [2:0] S_FILL   = 3'd4;  // blank fill sweep
  localparam logic [2:0] S_HOLD   = 3'd5;  // result waiting for out slot

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [3:0]        fg_r, bg_r;
  logic              rd_oor_r, rd_oor_nxt;
  logic              fill_scr_r, fill_scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  out_item_t         pend_r, pend_nxt;

  // store ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  cur_upd_t          upd;
  logic              finish;
  out_item_t         fin_item;
  logic              slot_free;
  logic [CELL_W-1:0] blank;
  logic [7:0]        colour;

  assign colour    = {bg_r, fg_r};
  assign blank     = {colour, CH_SPACE};
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tcw_ram #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor u_cursor (
    .cursor    (cursor_r),
    .col       (col_r),
    .char_code (in_data.char_code),
    .upd       (upd)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cursor_nxt   = cursor_r;
    col_nxt      = col_r;
    rd_oor_nxt   = rd_oor_r;
    fill_scr_nxt = fill_scr_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    finish       = 1'b0;
    fin_item     = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_PUT: begin
              if (upd.write_en) begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cursor_r);
                ram_wdata = {colour, in_data.char_code};
              end
              if (upd.scroll) begin
                cursor_nxt   = CUR_W'(CELLS - COLUMNS);
                col_nxt      = '0;
                cnt_nxt      = '0;
                fill_scr_nxt = 1'b1;
                state_nxt    = S_SCROLL;
              end else begin
                cursor_nxt          = upd.pos;
                col_nxt             = upd.col;
                finish              = 1'b1;
                fin_item.cursor_pos = POS_W'(upd.pos);
              end
            end
            OP_CLEAR: begin
              cursor_nxt   = '0;
              col_nxt      = '0;
              cnt_nxt      = '0;
              fill_scr_nxt = 1'b0;
              state_nxt    = S_FILL;
            end
            OP_READ: begin
              rd_oor_nxt = (in_data.read_addr >= POS_W'(CELLS));
              ram_re     = !rd_oor_nxt;
              ram_raddr  = ADDR_W'(in_data.read_addr);
              state_nxt  = S_READ;
            end
            default: begin
              finish              = 1'b1;
              fin_item.cursor_pos = POS_W'(cursor_r);
            end
          endcase
        end
      end
      S_READ: begin
        finish              = 1'b1;
        fin_item.cursor_pos = POS_W'(cursor_r);
        fin_item.cell_data  = rd_oor_r ? '0 : ram_rdata;
      end
      S_SCROLL: begin
        // read runs one cell ahead of the write
        if (cnt_r < ADDR_W'(CELLS - COLUMNS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + ADDR_W'(COLUMNS);
        end
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (cnt_r == ADDR_W'(CELLS - COLUMNS)) begin
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = blank;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          finish              = 1'b1;
          fin_item.cursor_pos = POS_W'(cursor_r);
          fin_item.scrolled   = fill_scr_r;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register and holding register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    if (state_r == S_HOLD && slot_free) begin
      out_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end
    if (finish) begin
      if (slot_free) begin
        out_nxt       = fin_item;
        out_valid_nxt = 1'b1;
      end else begin
        pend_nxt = fin_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      rd_oor_r    <= 1'b0;
      fill_scr_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= (finish && !slot_free) ? S_HOLD :
                     (finish ? S_IDLE : state_nxt);
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      rd_oor_r    <= rd_oor_nxt;
      fill_scr_r  <= fill_scr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'd7;
      bg_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG:  fg_r <= cfg_wdata;
        CFG_BG:  bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a scrolling transaction always reports the start of the last row
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.scrolled) |->
      (out_data.cursor_pos == POS_W'(CELLS - COLUMNS)))
    else $error("scroll result with wrong cursor");

  // cursor stays on the screen between transactions
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < CUR_W'(CELLS))
    else $error("cursor off screen");

  // store writes stay inside the store
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < ADDR_W'(CELLS)))
    else $error("store write out of range");

  // column register stays below COLUMNS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(COLUMNS))
    else $error("column out of range");

endmodule
